/* rtl/cwu_pkg.sv */
// Shared widths, constants, register indexes and multiplier handshake types.
package cwu_pkg;

  localparam int unsigned ProdW    = 160;  // widest cross product is 159 bits
  localparam int unsigned MplW     = 40;   // widest multiplier operand
  localparam int unsigned DigitW   = 8;    // multiplier bits retired per step
  localparam int unsigned TimeW    = 63;
  localparam int unsigned SeqW     = 48;
  localparam int unsigned WinW     = 32;
  localparam int unsigned RateW    = 40;
  localparam int unsigned RttW     = 40;
  localparam int unsigned QueueW   = 24;
  localparam int unsigned MssW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned PktW     = 11;

  // Picoseconds per second and the reference packet size.
  localparam logic [MplW-1:0] PsPerS   = 40'd1000000000000;
  localparam logic [PktW-1:0] PktBytes = 11'd1500;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMss      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinWin   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxWin   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLineRate = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInitWin  = 3'd4;

  // Register reset values.
  localparam logic [MssW-1:0]  MssReset      = 16'd1436;
  localparam logic [WinW-1:0]  MinWinReset   = 32'd1436;
  localparam logic [WinW-1:0]  MaxWinReset   = 32'hFFFF_FFFF;
  localparam logic [RateW-1:0] LineRateReset = 40'd12500000000;
  localparam logic [WinW-1:0]  InitWinReset  = 32'd57440;

  // Request to and response from the shared multiplier.
  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] mcand;
    logic [MplW-1:0]  mplier;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] product;
  } mul_rsp_t;

endpackage

/* rtl/congestion_window_update.sv */
// Per-flow sender congestion window, updated by ACKs and early-feedback notices.
// Input channel: in_valid_i / in_stall_o carry one beat per ACK (kind 0) or
// notice (kind 1). Output channel: out_valid_o / out_stall_i carry one beat
// per input beat with the new window and the decreased and clamped flags.
// The block works on one beat at a time; in_stall_o is high from the cycle
// after a beat is taken until its result is loaded into the output register.
// An ACK, or a notice with an empty queue, needs no products; other
// notices run a chain of cross products through the one shared 160-by-8-bit
// multiplier step, which retires 8 multiplier bits per cycle. When the rate
// check finds the link full, only the rate-check products and the two short
// products run; when rtt or line rate is zero, the rate check is skipped and
// only the two short products run; otherwise the whole chain runs.
// When the receiver stalls, the result waits in the output register; the next
// input beat is still taken, and its result waits for the register to empty.
// Reset loads the register defaults, sets the window to the initial window
// and clears the decrease time and the next-increase sequence number.
// Writing the initial window register also reloads the window.
module congestion_window_update (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [cwu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cwu_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [cwu_pkg::TimeW-1:0]   now_ps_i,
  input  logic [cwu_pkg::TimeW-1:0]   sent_time_ps_i,
  input  logic [cwu_pkg::QueueW-1:0]  queue_bytes_i,
  input  logic [cwu_pkg::RttW-1:0]    smoothed_rtt_ps_i,
  input  logic                        increase_flag_i,
  input  logic [cwu_pkg::SeqW-1:0]    ack_number_i,
  input  logic [cwu_pkg::SeqW-1:0]    highest_sent_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cwu_pkg::WinW-1:0]    window_bytes_o,
  output logic                        decreased_o,
  output logic                        clamped_o
);
  import cwu_pkg::*;

  // Sequencer states.
  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SStart = 2'd1;
  localparam logic [1:0] SWait  = 2'd2;
  localparam logic [1:0] SFin   = 2'd3;

  // Multiplier operations in issue order.
  localparam logic [2:0] OpWinPs   = 3'd0;  // lhs = window * 1e12
  localparam logic [2:0] OpRateRtt = 3'd1;  // rhs = line rate * rtt
  localparam logic [2:0] OpAgePkt  = 3'd2;  // lhs = age * 1500
  localparam logic [2:0] OpSinceQ  = 3'd3;  // rhs = since * queue
  localparam logic [2:0] OpLhsRate = 3'd4;  // lhs = lhs * line rate
  localparam logic [2:0] OpLhsRtt  = 3'd5;  // lhs = lhs * rtt
  localparam logic [2:0] OpRhsWin  = 3'd6;  // rhs = rhs * window
  localparam logic [2:0] OpRhsPs   = 3'd7;  // rhs = rhs * 1e12

  localparam int unsigned SumW = WinW + 2;

  // Configuration and flow state.
  logic [MssW-1:0]  mss_q;
  logic [WinW-1:0]  min_win_q;
  logic [WinW-1:0]  max_win_q;
  logic [RateW-1:0] line_rate_q;
  logic [WinW-1:0]  window_q;
  logic [TimeW-1:0] last_dec_q;
  logic [SeqW-1:0]  next_seq_q;

  // Sequencer.
  logic [1:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic       full_q, full_d;
  logic       chk_q, chk_d;

  // Latched beat.
  logic              kind_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  age_q;
  logic [TimeW-1:0]  since_q;
  logic [QueueW-1:0] queue_q;
  logic [RttW-1:0]   rtt_q;
  logic              inc_q;
  logic [SeqW-1:0]   ack_q;
  logic [SeqW-1:0]   high_q;

  // Cross-product operands.
  logic [ProdW-1:0] lhs_q;
  logic [ProdW-1:0] rhs_q;
  logic             lhs_lt_rhs;
  logic             dest_lhs;

  // Output register.
  logic            out_valid_q;
  logic [WinW-1:0] window_bytes_q;
  logic            decreased_q;
  logic            clamped_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic            in_accept;
  logic            fin_load;
  logic            dec;
  logic [WinW-1:0] dec_win;
  logic [SumW-1:0] ack_sum;
  logic [SumW-1:0] ack_lo;
  logic            below_min;
  logic            above_max;
  logic [WinW-1:0] ack_win;
  logic [WinW-1:0] next_win;
  logic            rate_check;

  assign in_stall_o = (state_q != SIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fin_load   = (state_q == SFin) && (!out_valid_q || !out_stall_i);
  assign rate_check = (smoothed_rtt_ps_i != '0) && (line_rate_q != '0);

  // One comparator serves both the rate check and the final decision.
  assign lhs_lt_rhs = (lhs_q < rhs_q);
  assign dest_lhs   = op_q inside {OpWinPs, OpAgePkt, OpLhsRate, OpLhsRtt};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.start = (state_q == SStart);
    case (op_q)
      OpWinPs: begin
        mul_req.mcand  = ProdW'(window_q);
        mul_req.mplier = PsPerS;
      end
      OpRateRtt: begin
        mul_req.mcand  = ProdW'(line_rate_q);
        mul_req.mplier = rtt_q;
      end
      OpAgePkt: begin
        mul_req.mcand  = ProdW'(age_q);
        mul_req.mplier = MplW'(PktBytes);
      end
      OpSinceQ: begin
        mul_req.mcand  = ProdW'(since_q);
        mul_req.mplier = MplW'(queue_q);
      end
      OpLhsRate: begin
        mul_req.mcand  = lhs_q;
        mul_req.mplier = line_rate_q;
      end
      OpLhsRtt: begin
        mul_req.mcand  = lhs_q;
        mul_req.mplier = rtt_q;
      end
      OpRhsWin: begin
        mul_req.mcand  = rhs_q;
        mul_req.mplier = MplW'(window_q);
      end
      OpRhsPs: begin
        mul_req.mcand  = rhs_q;
        mul_req.mplier = PsPerS;
      end
      default: begin
        mul_req.mcand  = '0;
        mul_req.mplier = '0;
      end
    endcase
  end

  cwu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sequencer next state. A full link (or a zero rtt or rate) needs only the
  // two short products beyond any rate check; else the rate terms scale both.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    full_d  = full_q;
    chk_d   = chk_q;
    case (state_q)
      SIdle: begin
        if (in_accept) begin
          if (kind_i && (queue_bytes_i != '0)) begin
            state_d = SStart;
            chk_d   = rate_check;
            full_d  = !rate_check;
            op_d    = rate_check ? OpWinPs : OpAgePkt;
          end else begin
            state_d = SFin;
          end
        end
      end
      SStart: begin
        if (op_q == OpAgePkt && chk_q) begin
          full_d = !lhs_lt_rhs;
        end
        state_d = SWait;
      end
      SWait: begin
        if (mul_rsp.done) begin
          if ((op_q == OpSinceQ && full_q) || op_q == OpRhsPs) begin
            state_d = SFin;
          end else begin
            op_d    = op_q + 3'd1;
            state_d = SStart;
          end
        end
      end
      SFin: begin
        if (fin_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      op_q    <= OpWinPs;
      full_q  <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      full_q  <= full_d;
      chk_q   <= chk_d;
    end
  end

  // Latch the beat and both time differences, modulo 2^63.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      now_q   <= now_ps_i;
      age_q   <= now_ps_i - sent_time_ps_i;
      since_q <= now_ps_i - last_dec_q;
      queue_q <= queue_bytes_i;
      rtt_q   <= smoothed_rtt_ps_i;
      inc_q   <= increase_flag_i;
      ack_q   <= ack_number_i;
      high_q  <= highest_sent_i;
    end
  end

  // Products land in the side their operation names.
  always_ff @(posedge clk_i) begin
    if (state_q == SWait && mul_rsp.done) begin
      if (dest_lhs) begin
        lhs_q <= mul_rsp.product;
      end else begin
        rhs_q <= mul_rsp.product;
      end
    end
  end

  // Notice result: one MSS down, saturating at zero.
  assign dec     = kind_q && (queue_q != '0) && lhs_lt_rhs;
  assign dec_win = (window_q >= WinW'(mss_q)) ? (window_q - WinW'(mss_q)) : '0;

  // ACK result: add the steps without wrap, then clamp; the max clamp wins.
  always_comb begin
    ack_sum = SumW'(window_q);
    if (inc_q) begin
      ack_sum = ack_sum + SumW'(mss_q);
    end
    if (ack_q >= next_seq_q) begin
      ack_sum = ack_sum + SumW'(mss_q);
    end
    below_min = (ack_sum < SumW'(min_win_q));
    ack_lo    = below_min ? SumW'(min_win_q) : ack_sum;
    above_max = (ack_lo > SumW'(max_win_q));
    ack_win   = above_max ? max_win_q : ack_lo[WinW-1:0];
  end

  always_comb begin
    if (kind_q) begin
      next_win = dec ? dec_win : window_q;
    end else begin
      next_win = ack_win;
    end
  end

  // Configuration registers and flow state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_q       <= MssReset;
      min_win_q   <= MinWinReset;
      max_win_q   <= MaxWinReset;
      line_rate_q <= LineRateReset;
      window_q    <= InitWinReset;
      last_dec_q  <= '0;
      next_seq_q  <= '0;
    end else if (fin_load) begin
      window_q <= next_win;
      if (dec) begin
        last_dec_q <= now_q;
      end
      if (!kind_q && (ack_q >= next_seq_q)) begin
        next_seq_q <= high_q + SeqW'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMss:      mss_q       <= cfg_data_i[MssW-1:0];
        RegMinWin:   min_win_q   <= cfg_data_i[WinW-1:0];
        RegMaxWin:   max_win_q   <= cfg_data_i[WinW-1:0];
        RegLineRate: line_rate_q <= cfg_data_i[RateW-1:0];
        RegInitWin:  window_q    <= cfg_data_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // Output register; a waiting result holds until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      window_bytes_q <= next_win;
      decreased_q    <= dec;
      clamped_q      <= !kind_q && (below_min || above_max);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_bytes_o = window_bytes_q;
  assign decreased_o    = decreased_q;
  assign clamped_o      = clamped_q;

`ifndef ASSERT_OFF
  // A taken beat closes the input until its result is loaded.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after a beat was taken");

  // The multiplier only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == SWait))
    else $error("multiplier finished outside the wait state");

  // A result is never both a decrease and a clamp.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(decreased_o && clamped_o))
    else $error("decreased and clamped both set");

  // A notice never raises the window.
  a_notice_no_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && kind_q) |=> (window_q <= $past(window_q)))
    else $error("notice raised the window");
`endif

endmodule

/* rtl/cwu_mul.sv */
// Shared digit-serial multiplier: wide multiplicand times a 40-bit operand, 8 bits a step.
module cwu_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwu_pkg::mul_req_t req_i,
  output cwu_pkg::mul_rsp_t rsp_o
);
  import cwu_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [ProdW-1:0]        acc_q;
  logic [ProdW-1:0]        acc_d;
  logic [ProdW-1:0]        mcand_q;
  logic [MplW-1:0]         mplier_q;
  logic [ProdW+DigitW-1:0] pp;
  logic                    last;

  // One partial product per step; the shifted multiplicand never loses set
  // bits because every product that is formed fits in ProdW bits.
  always_comb begin
    pp    = {{DigitW{1'b0}}, mcand_q} * {{ProdW{1'b0}}, mplier_q[DigitW-1:0]};
    acc_d = acc_q + pp[ProdW-1:0];
    last  = (mplier_q[MplW-1:DigitW] == '0);
  end

  // Step control: done pulses for one cycle after the last digit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !last;
      done_q <= last;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Accumulator and operand shift registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q    <= '0;
      mcand_q  <= req_i.mcand;
      mplier_q <= req_i.mplier;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= {mcand_q[ProdW-DigitW-1:0], {DigitW{1'b0}}};
      mplier_q <= {{DigitW{1'b0}}, mplier_q[MplW-1:DigitW]};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule
